/* rtl/core/gbn_pkg.sv */
// Shared types, codes and constants of the go-back-n sender core.
package gbn_pkg;

   localparam int SEQ_BITS   = 16;
   localparam int MAX_WINDOW = 32;
   localparam int WIN_W      = 6;
   localparam int TMO_W      = 16;
   localparam int TIMER_W    = 17;
   localparam int TICK_W     = 16;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

   // result word kinds
   localparam logic [1:0] KIND_NEW  = 2'd0;
   localparam logic [1:0] KIND_RETX = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // ack kinds of a request word
   localparam logic [1:0] ACK_NONE  = 2'd0;
   localparam logic [1:0] ACK_EMPTY = 2'd1;
   localparam logic [1:0] ACK_SEQ   = 2'd2;

   // configuration register indexes
   localparam logic CSR_WINDOW  = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(8);
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(1000);

   typedef struct packed {
      logic                frame_ready;
      logic                frame_is_final;
      logic [1:0]          ack_kind;
      logic [SEQ_BITS-1:0] ack_seq;
      logic [TICK_W-1:0]   elapsed_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SEQ_BITS-1:0] seq_num;
      logic                last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAME,
      ST_ACK,
      ST_TIMER,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic step_frame;
      logic step_ack;
      logic step_timer;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic have_word;
      logic word_last;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/gbn_ctrl.sv */
// Step sequencer of the go-back-n sender: accept, three update phases, emission.
module gbn_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gbn_pkg::status_type  status,
   output gbn_pkg::cmd_type     cmd
);

   gbn_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_stall = 1'b1;
      case (state_ff)
         gbn_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = gbn_pkg::ST_FRAME;
            end
         end
         gbn_pkg::ST_FRAME: begin
            cmd.step_frame = 1'b1;
            state_in       = gbn_pkg::ST_ACK;
         end
         gbn_pkg::ST_ACK: begin
            cmd.step_ack = 1'b1;
            state_in     = gbn_pkg::ST_TIMER;
         end
         gbn_pkg::ST_TIMER: begin
            cmd.step_timer = 1'b1;
            state_in       = gbn_pkg::ST_EMIT;
         end
         gbn_pkg::ST_EMIT: begin
            if (!status.have_word) begin
               state_in = gbn_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.word_last) begin
                  state_in = gbn_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = gbn_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/gbn_dp.sv */
// Datapath of the go-back-n sender: window state, timer, pending words, output register.
module gbn_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   input  gbn_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gbn_pkg::rsp_type     rsp_data,
   input  gbn_pkg::cmd_type     cmd,
   output gbn_pkg::status_type  status
);

   localparam int SB = gbn_pkg::SEQ_BITS;

   logic [gbn_pkg::WIN_W-1:0]   window_ff, window_in;
   logic [gbn_pkg::TMO_W-1:0]   timeout_ff, timeout_in;

   gbn_pkg::req_type            req_ff, req_in;
   logic [SB-1:0]               base_ff, base_in;
   logic [SB-1:0]               next_ff, next_in;
   logic [SB-1:0]               final_seq_ff, final_seq_in;
   logic                        final_known_ff, final_known_in;
   logic                        src_done_ff, src_done_in;
   logic                        timer_on_ff, timer_on_in;
   logic [gbn_pkg::TIMER_W-1:0] timer_ff, timer_in;
   logic                        finished_ff, finished_in;

   logic                        pend_new_ff, pend_new_in;
   logic [SB-1:0]               new_seq_ff, new_seq_in;
   logic                        pend_done_ff, pend_done_in;
   logic [gbn_pkg::CNT_W-1:0]   retx_left_ff, retx_left_in;
   logic [SB-1:0]               retx_seq_ff, retx_seq_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   gbn_pkg::rsp_type            rsp_ff, rsp_in;

   logic [gbn_pkg::WIN_W-1:0]   win_eff;
   logic [SB-1:0]               outstanding;
   logic [SB-1:0]               ack_dist;
   logic [gbn_pkg::TIMER_W:0]   timer_sum;
   gbn_pkg::rsp_type            word;
   logic                        out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= gbn_pkg::WINDOW_RESET;
         timeout_ff     <= gbn_pkg::TIMEOUT_RESET;
         base_ff        <= '0;
         next_ff        <= '0;
         final_seq_ff   <= '0;
         final_known_ff <= 1'b0;
         src_done_ff    <= 1'b0;
         timer_on_ff    <= 1'b0;
         timer_ff       <= '0;
         finished_ff    <= 1'b0;
         pend_new_ff    <= 1'b0;
         pend_done_ff   <= 1'b0;
         retx_left_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         timeout_ff     <= timeout_in;
         base_ff        <= base_in;
         next_ff        <= next_in;
         final_seq_ff   <= final_seq_in;
         final_known_ff <= final_known_in;
         src_done_ff    <= src_done_in;
         timer_on_ff    <= timer_on_in;
         timer_ff       <= timer_in;
         finished_ff    <= finished_in;
         pend_new_ff    <= pend_new_in;
         pend_done_ff   <= pend_done_in;
         retx_left_ff   <= retx_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      new_seq_ff  <= new_seq_in;
      retx_seq_ff <= retx_seq_in;
      rsp_ff      <= rsp_in;
   end

   // window clamp to 1..MAX_WINDOW
   always_comb begin
      win_eff = window_ff;
      if (window_ff == '0) begin
         win_eff = gbn_pkg::WIN_W'(1);
      end else if (window_ff > gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW)) begin
         win_eff = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
      end
   end

   assign outstanding = next_ff - base_ff;
   assign ack_dist    = req_ff.ack_seq - base_ff;
   assign timer_sum   = {1'b0, timer_ff} + (gbn_pkg::TIMER_W + 1)'(req_ff.elapsed_ticks);

   // next result word, in emission order: new frame, completion, retransmissions
   always_comb begin
      word = '0;
      if (pend_new_ff) begin
         word.kind    = gbn_pkg::KIND_NEW;
         word.seq_num = new_seq_ff;
         word.last    = !pend_done_ff && (retx_left_ff == '0);
      end else if (pend_done_ff) begin
         word.kind    = gbn_pkg::KIND_DONE;
         word.seq_num = final_seq_ff;
         word.last    = (retx_left_ff == '0);
      end else begin
         word.kind    = gbn_pkg::KIND_RETX;
         word.seq_num = retx_seq_ff;
         word.last    = (retx_left_ff == gbn_pkg::CNT_W'(1));
      end
   end

   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign status.have_word = pend_new_ff || pend_done_ff || (retx_left_ff != '0);
   assign status.word_last = word.last;
   assign status.out_free  = out_free;

   always_comb begin
      window_in      = window_ff;
      timeout_in     = timeout_ff;
      req_in         = req_ff;
      base_in        = base_ff;
      next_in        = next_ff;
      final_seq_in   = final_seq_ff;
      final_known_in = final_known_ff;
      src_done_in    = src_done_ff;
      timer_on_in    = timer_on_ff;
      timer_in       = timer_ff;
      finished_in    = finished_ff;
      pend_new_in    = pend_new_ff;
      new_seq_in     = new_seq_ff;
      pend_done_in   = pend_done_ff;
      retx_left_in   = retx_left_ff;
      retx_seq_in    = retx_seq_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            gbn_pkg::CSR_WINDOW:  window_in  = csr_wdata[gbn_pkg::WIN_W-1:0];
            gbn_pkg::CSR_TIMEOUT: timeout_in = csr_wdata[gbn_pkg::TMO_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         req_in = req_data;
      end

      // timer advance and new frame
      if (cmd.step_frame && !finished_ff) begin
         if (timer_on_ff) begin
            timer_in = timer_sum[gbn_pkg::TIMER_W] ? '1 : timer_sum[gbn_pkg::TIMER_W-1:0];
         end
         if (!src_done_ff && req_ff.frame_ready &&
             outstanding < SB'(win_eff)) begin
            pend_new_in = 1'b1;
            new_seq_in  = next_ff;
            if (req_ff.frame_is_final) begin
               final_seq_in   = next_ff;
               final_known_in = 1'b1;
               src_done_in    = 1'b1;
            end
            next_in = next_ff + SB'(1);
         end
      end

      // acknowledgement
      if (cmd.step_ack && !finished_ff) begin
         case (req_ff.ack_kind)
            gbn_pkg::ACK_SEQ: begin
               if (final_known_ff && req_ff.ack_seq == final_seq_ff) begin
                  pend_done_in = 1'b1;
                  finished_in  = 1'b1;
                  timer_on_in  = 1'b0;
               end else if (ack_dist < outstanding) begin
                  base_in     = req_ff.ack_seq + SB'(1);
                  timer_on_in = 1'b0;
               end
            end
            gbn_pkg::ACK_EMPTY: ;
            default: begin
               if (!timer_on_ff) begin
                  timer_on_in = 1'b1;
                  timer_in    = '0;
               end
            end
         endcase
      end

      // timeout: queue the whole outstanding range for retransmission
      if (cmd.step_timer && timer_on_ff &&
          timer_ff > gbn_pkg::TIMER_W'(timeout_ff)) begin
         if (outstanding > SB'(gbn_pkg::MAX_WINDOW)) begin
            retx_left_in = gbn_pkg::CNT_W'(gbn_pkg::MAX_WINDOW);
         end else begin
            retx_left_in = outstanding[gbn_pkg::CNT_W-1:0];
         end
         retx_seq_in = base_ff;
         timer_in    = '0;
      end

      // output register
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_in       = word;
         if (pend_new_ff) begin
            pend_new_in = 1'b0;
         end else if (pend_done_ff) begin
            pend_done_in = 1'b0;
         end else begin
            retx_left_in = retx_left_ff - gbn_pkg::CNT_W'(1);
            retx_seq_in  = retx_seq_ff + SB'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/go_back_n_sender_core.sv */
// Top level of the go-back-n ARQ sender core: sequencer plus datapath.
//
// Usage:
//  - req_* carries one loop step of the sender: frame ready / final flags,
//    an optional cumulative ack and the ticks elapsed since the last step.
//    A word is taken when req_valid is high and req_stall is low.
//  - rsp_* delivers the words caused by that step, in order: a new frame,
//    a transfer-complete word, then any retransmissions from the base up.
//    rsp_data.last marks the final word of a step. A step may cause none.
//  - csr_* writes the window limit (index 0) and timeout_ticks (index 1);
//    write only while the core is idle.
// Timing:
//  - After acceptance, three update phases (timer and new frame, ack,
//    timeout check), then one result word per cycle while rsp_stall is
//    low; req_stall stays high until the last word of the step is loaded.
//    A step yields at most 33 words: a new frame plus a 32-frame retransmit window.
//  - The single output register paces emission: while rsp_stall is high
//    the pending word holds and the sequencer waits in its emit phase.
// Reset (synchronous, active high) clears the window, timer and finished
// flag, restores a window limit of 8 and timeout_ticks 1000, drops rsp_valid.
// Once the transfer completes every later step yields no words until reset.
module go_back_n_sender_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbn_pkg::rsp_type  rsp_data
);

   gbn_pkg::cmd_type    cmd;
   gbn_pkg::status_type status;

   // phase sequencer; holds req_stall high for the whole step
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // window state, timer, pending result words and the output register
   gbn_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
